>>> src/gbnf_pkg.sv
// Shared codes and reset values for the go-back-N forwarder.
package gbnf_pkg;

    typedef enum logic [1:0] {
        OP_DATA = 2'd0,
        OP_ACK  = 2'd1,
        OP_TICK = 2'd2,
        OP_NONE = 2'd3
    } op_t;

    localparam logic KIND_ACK = 1'b0;
    localparam logic KIND_FWD = 1'b1;

    localparam logic CFG_WINDOW  = 1'b0;
    localparam logic CFG_TIMEOUT = 1'b1;

    localparam logic [5:0]  WINDOW_RESET  = 6'd4;
    localparam logic [31:0] TIMEOUT_RESET = 32'd1000;

endpackage

>>> src/go_back_n_forwarder.sv
// Go-back-N relay: top level with the queue memory and the control sequencer.
//
// Usage: an input item (op, seq_value, payload, well_formed, intact) is taken
// at a rising edge where start is high and busy is low. Well-formed, intact
// data items that carry the expected number are acknowledged, stored in a
// ring queue and forwarded when the held count stays within the window.
// Acknowledgements from the receiver free queue slots and forward waiting
// entries. Ticks count idle time and at the timeout the window is resent
// from the oldest held slot. Configuration (window size, timeout) is written
// through cfg_we, cfg_index and cfg_data with no wait; the user must write it
// only while the block is idle, as the block itself does not enforce this.
// Results appear on kind, number, out_payload and last for exactly one cycle,
// marked by result_valid; the receiver cannot stall them. An item is latched,
// then evaluated (the acknowledgement of a data item appears after it), and
// then its forwarded entries follow one per cycle, since each forward reads
// the payload memory through its single read port. Reset clears all control
// state and restores the register defaults; the payload memory is not
// cleared, as only held slots are ever read.
module go_back_n_forwarder #(
    parameter int QUEUE_DEPTH = 64,
    parameter int WINDOW_MAX  = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  op,
    input  logic [30:0] seq_value,
    input  logic [31:0] payload,
    input  logic        well_formed,
    input  logic        intact,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data,
    output logic        result_valid,
    output logic        kind,
    output logic [30:0] number,
    output logic [31:0] out_payload,
    output logic        last
);

    localparam int SLOT_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int WIN_W  = $clog2(WINDOW_MAX + 1);
    localparam int CW     = (CNT_W > WIN_W) ? CNT_W : WIN_W;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVAL,
        ST_SEND
    } state_t;

    state_t             state_reg;
    logic               busy_reg;
    logic [1:0]         op_reg;
    logic [30:0]        seq_reg;
    logic [31:0]        pay_reg;
    logic               wf_reg;
    logic               ok_reg;
    logic [5:0]         window_reg;
    logic [31:0]        timeout_reg;
    logic [30:0]        exp_reg;
    logic [SLOT_W-1:0]  write_slot_reg;
    logic [SLOT_W-1:0]  oldest_reg;
    logic [SLOT_W-1:0]  newest_reg;
    logic [CW-1:0]      held_reg;
    logic [31:0]        idle_reg;
    logic [SLOT_W-1:0]  cur_reg;
    logic [CW-1:0]      rem_reg;
    logic               strobe_reg;
    logic               kind_reg;
    logic [30:0]        number_reg;
    logic               last_reg;

    logic [31:0]        mem [QUEUE_DEPTH];
    logic [31:0]        rd_data_reg;

    // Evaluation results for the latched item.
    logic               ev_ack;
    logic               ev_store;
    logic [CW-1:0]      ev_n;
    logic [SLOT_W-1:0]  ev_start;
    logic [CW-1:0]      ev_held_next;
    logic [SLOT_W-1:0]  ev_oldest_next;
    logic [SLOT_W-1:0]  ev_write_next;
    logic [30:0]        ev_exp_next;
    logic [31:0]        ev_idle_next;

    function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
        logic [SLOT_W-1:0] r;
        if ({1'b0, s} == (SLOT_W + 1)'(QUEUE_DEPTH - 1)) r = '0;
        else r = s + SLOT_W'(1);
        return r;
    endfunction

    // Distance from base forward to s around the ring.
    function automatic logic [SLOT_W-1:0] ring_off(input logic [SLOT_W-1:0] s,
                                                   input logic [SLOT_W-1:0] base);
        logic [SLOT_W:0] d;
        d = {1'b0, s} - {1'b0, base};
        if (d[SLOT_W]) d = d + (SLOT_W + 1)'(QUEUE_DEPTH);
        return d[SLOT_W-1:0];
    endfunction

    always_comb
    begin
        logic [CW-1:0]     win;
        logic [CW-1:0]     cnt;
        logic [CW-1:0]     lim;
        logic [CW-1:0]     offp;
        logic [CW-1:0]     avail;
        logic [SLOT_W-1:0] ack_slot;
        logic [SLOT_W-1:0] p;
        logic [31:0]       idle_inc;

        win = (CW'(window_reg) > CW'(WINDOW_MAX)) ? CW'(WINDOW_MAX) : CW'(window_reg);
        ack_slot = seq_reg[SLOT_W-1:0];
        cnt = CW'(ring_off(ack_slot, oldest_reg)) + CW'(1);
        lim = '0;
        offp = '0;
        avail = '0;
        p = next_slot(newest_reg);
        idle_inc = (idle_reg == 32'hFFFF_FFFF) ? idle_reg : idle_reg + 32'd1;

        ev_ack = 1'b0;
        ev_store = 1'b0;
        ev_n = '0;
        ev_start = oldest_reg;
        ev_held_next = held_reg;
        ev_oldest_next = oldest_reg;
        ev_write_next = write_slot_reg;
        ev_exp_next = exp_reg;
        ev_idle_next = idle_reg;

        unique case (gbnf_pkg::op_t'(op_reg))
            gbnf_pkg::OP_DATA:
            begin
                if (held_reg != CW'(QUEUE_DEPTH)) begin
                    if (seq_reg == exp_reg) begin
                        if (wf_reg && ok_reg) begin
                            ev_ack = 1'b1;
                            ev_store = 1'b1;
                            ev_held_next = held_reg + CW'(1);
                            if (ev_held_next <= win) begin
                                ev_n = CW'(1);
                                ev_start = write_slot_reg;
                            end
                            ev_write_next = next_slot(write_slot_reg);
                            ev_exp_next = exp_reg + 31'd1;
                        end
                    end else if (seq_reg == exp_reg - 31'd1) begin
                        ev_ack = wf_reg;
                    end
                end
            end
            gbnf_pkg::OP_ACK:
            begin
                if (seq_reg < 31'(QUEUE_DEPTH) && held_reg != '0
                    && CW'(ring_off(ack_slot, oldest_reg)) < held_reg) begin
                    ev_held_next = held_reg - cnt;
                    ev_oldest_next = next_slot(ack_slot);
                    lim = (cnt > win) ? win : cnt;
                    offp = CW'(ring_off(p, ev_oldest_next));
                    avail = (offp < ev_held_next) ? ev_held_next - offp : '0;
                    ev_n = (lim > avail) ? avail : lim;
                    ev_start = p;
                end
            end
            gbnf_pkg::OP_TICK:
            begin
                if (held_reg != '0) begin
                    ev_idle_next = idle_inc;
                    if (idle_inc >= timeout_reg) begin
                        ev_n = (win > held_reg) ? held_reg : win;
                        ev_start = oldest_reg;
                    end
                end
            end
            default:
            begin
                ev_n = '0;
            end
        endcase
    end

    // Queue memory: written when a data item is stored, read once per forward.
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_EVAL && ev_store) begin
            mem[write_slot_reg] <= pay_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_SEND) begin
            rd_data_reg <= mem[cur_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg      <= ST_IDLE;
            busy_reg       <= 1'b0;
            window_reg     <= gbnf_pkg::WINDOW_RESET;
            timeout_reg    <= gbnf_pkg::TIMEOUT_RESET;
            exp_reg        <= '0;
            write_slot_reg <= '0;
            oldest_reg     <= '0;
            newest_reg     <= '0;
            held_reg       <= '0;
            idle_reg       <= '0;
            cur_reg        <= '0;
            rem_reg        <= '0;
            strobe_reg     <= 1'b0;
            kind_reg       <= gbnf_pkg::KIND_ACK;
            number_reg     <= '0;
            last_reg       <= 1'b0;
            op_reg         <= '0;
            seq_reg        <= '0;
            pay_reg        <= '0;
            wf_reg         <= 1'b0;
            ok_reg         <= 1'b0;
        end else begin
            strobe_reg <= 1'b0;
            if (cfg_we) begin
                if (cfg_index == gbnf_pkg::CFG_WINDOW) window_reg <= cfg_data[5:0];
                else timeout_reg <= cfg_data;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (start) begin
                        op_reg    <= op;
                        seq_reg   <= seq_value;
                        pay_reg   <= payload;
                        wf_reg    <= well_formed;
                        ok_reg    <= intact;
                        busy_reg  <= 1'b1;
                        state_reg <= ST_EVAL;
                    end
                end
                ST_EVAL:
                begin
                    held_reg       <= ev_held_next;
                    oldest_reg     <= ev_oldest_next;
                    write_slot_reg <= ev_write_next;
                    exp_reg        <= ev_exp_next;
                    idle_reg       <= ev_idle_next;
                    cur_reg        <= ev_start;
                    rem_reg        <= ev_n;
                    if (ev_ack) begin
                        strobe_reg <= 1'b1;
                        kind_reg   <= gbnf_pkg::KIND_ACK;
                        number_reg <= seq_reg;
                        last_reg   <= (ev_n == '0);
                    end
                    if (ev_n == '0) begin
                        busy_reg  <= 1'b0;
                        state_reg <= ST_IDLE;
                    end else begin
                        state_reg <= ST_SEND;
                    end
                end
                ST_SEND:
                begin
                    // The memory read issued here lands together with the strobe.
                    strobe_reg <= 1'b1;
                    kind_reg   <= gbnf_pkg::KIND_FWD;
                    number_reg <= 31'(cur_reg);
                    last_reg   <= (rem_reg == CW'(1));
                    newest_reg <= cur_reg;
                    idle_reg   <= '0;
                    cur_reg    <= next_slot(cur_reg);
                    rem_reg    <= rem_reg - CW'(1);
                    if (rem_reg == CW'(1)) begin
                        busy_reg  <= 1'b0;
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign busy         = busy_reg;
    assign result_valid = strobe_reg;
    assign kind         = kind_reg;
    assign number       = number_reg;
    assign last         = last_reg;
    assign out_payload  = (kind_reg == gbnf_pkg::KIND_FWD) ? rd_data_reg : 32'd0;

endmodule

>>> src/gbnf_checker.sv
// Port-level checks for the go-back-N forwarder and their binding.
module gbnf_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        result_valid,
    input logic        kind,
    input logic [31:0] out_payload,
    input logic        last
);

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted item did not raise busy");

    a_burst: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !last |=> result_valid)
        else $error("result burst broken before last");

    a_ack_then_fwd: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && kind == gbnf_pkg::KIND_ACK && !last
        |=> kind == gbnf_pkg::KIND_FWD)
        else $error("non-final acknowledgement not followed by a forward");

    a_ack_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && kind == gbnf_pkg::KIND_ACK |-> out_payload == 32'd0)
        else $error("acknowledgement carries a payload");

endmodule

bind go_back_n_forwarder gbnf_checker u_gbnf_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .result_valid (result_valid),
    .kind         (kind),
    .out_payload  (out_payload),
    .last         (last)
);
